>>> design/esfs_pkg.sv
// Shared constants and controller/datapath handshake types for the FFT size selector.
package esfs_pkg;

	// Largest length that can be chosen is 2**LENGTH_BITS
	localparam int LENGTH_BITS = 24;

	// Request and result field widths
	localparam int LEN_W    = 25;
	localparam int TWOS_W   = 5;
	localparam int THREES_W = 4;
	localparam int FIVES_W  = 4;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // capture a new request and set up the search
		logic dbl;      // double the starting candidate 2**a until it reaches n
		logic visit;    // compare the current candidate against the best so far
		logic next_c;   // move to the next power of five in this row
		logic next_b;   // move to the next power of three, back to c = 0
		logic publish;  // copy the best candidate into the result register
	} esfs_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic need_double;  // starting candidate still below n
		logic c_room;       // 2*3^b*5^(c+1) still within the limit
		logic b_room;       // 2*3^(b+1) still within the limit
	} esfs_stat_t;

endpackage

>>> design/esfs_req_if.sv
// Request channel: proposed transform length.
interface esfs_req_if import esfs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] proposed_length;

	modport source (output valid, output proposed_length, input ready);
	modport sink   (input valid, input proposed_length, output ready);
endinterface

>>> design/esfs_rsp_if.sv
// Result channel: chosen transform length and its exponents.
interface esfs_rsp_if import esfs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LEN_W-1:0]    chosen_length;
	logic [TWOS_W-1:0]   twos_exponent;
	logic [THREES_W-1:0] threes_exponent;
	logic [FIVES_W-1:0]  fives_exponent;

	modport source (output valid, output chosen_length, output twos_exponent,
		output threes_exponent, output fives_exponent, input ready);
	modport sink   (input valid, input chosen_length, input twos_exponent,
		input threes_exponent, input fives_exponent, output ready);
endinterface

>>> design/esfs_dp.sv
// Datapath of the size selector: candidate registers, best tracker and result register.
module esfs_dp import esfs_pkg::*; (
	input  logic                clk,
	input  logic [LEN_W-1:0]    proposed_length,
	input  esfs_cmd_t           cmd,
	output esfs_stat_t          st,
	output logic [LEN_W-1:0]    chosen_length,
	output logic [TWOS_W-1:0]   twos_exponent,
	output logic [THREES_W-1:0] threes_exponent,
	output logic [FIVES_W-1:0]  fives_exponent
);

	// candidates stay below 2**(LENGTH_BITS+1): below 2n when a > 1, at most 2**LENGTH_BITS when a = 1
	localparam int VW   = LENGTH_BITS + 1;
	localparam int XW   = VW + 3;
	localparam int AW   = $clog2(LENGTH_BITS + 1);
	localparam int CMPW = (VW > LEN_W) ? VW : LEN_W;
	localparam logic [VW-1:0]   LIMIT   = VW'(1) << LENGTH_BITS;
	localparam logic [CMPW-1:0] LIMIT_C = CMPW'(1) << LENGTH_BITS;
	localparam logic [AW-1:0]   A_TOP   = AW'(LENGTH_BITS);

	logic [VW-1:0]       n_q;
	logic [VW-1:0]       v_row_q, v_cur_q;   // smallest 2^a*3^b*5^c >= n for row / cell
	logic [AW-1:0]       a_row_q, a_cur_q;
	logic [VW-1:0]       p_row_q, p_cur_q;   // 2*3^b and 2*3^b*5^c
	logic [THREES_W-1:0] b_q;
	logic [FIVES_W-1:0]  c_q;
	logic [VW-1:0]       best_q;
	logic [AW-1:0]       best_a_q;
	logic [THREES_W-1:0] best_b_q;
	logic [FIVES_W-1:0]  best_c_q;

	logic [CMPW-1:0] req_ext;
	logic [VW-1:0]   n_clamped;
	logic [XW-1:0]   n_x;
	logic [XW-1:0]   x5, x3;
	logic [VW-1:0]   v5, v3;
	logic [AW-1:0]   a5, a3;
	logic [XW-1:0]   p5, p3;

	// clamp the request into [2, 2**LENGTH_BITS]
	always_comb begin
		req_ext = CMPW'(proposed_length);
		priority if (req_ext > LIMIT_C) begin
			n_clamped = LIMIT;
		end else if (req_ext < CMPW'(2)) begin
			n_clamped = VW'(2);
		end else begin
			n_clamped = VW'(req_ext);
		end
	end

	assign n_x = XW'(n_q);

	// times five, then drop up to three factors of two while still >= n
	assign x5 = (XW'(v_cur_q) << 2) + XW'(v_cur_q);
	always_comb begin
		priority if (a_cur_q > AW'(3) && (x5 >> 3) >= n_x) begin
			v5 = VW'(x5 >> 3);
			a5 = a_cur_q - AW'(3);
		end else if (a_cur_q > AW'(2) && (x5 >> 2) >= n_x) begin
			v5 = VW'(x5 >> 2);
			a5 = a_cur_q - AW'(2);
		end else if (a_cur_q > AW'(1) && (x5 >> 1) >= n_x) begin
			v5 = VW'(x5 >> 1);
			a5 = a_cur_q - AW'(1);
		end else begin
			v5 = VW'(x5);
			a5 = a_cur_q;
		end
	end

	// times three on the row start, then drop up to two factors of two
	assign x3 = (XW'(v_row_q) << 1) + XW'(v_row_q);
	always_comb begin
		priority if (a_row_q > AW'(2) && (x3 >> 2) >= n_x) begin
			v3 = VW'(x3 >> 2);
			a3 = a_row_q - AW'(2);
		end else if (a_row_q > AW'(1) && (x3 >> 1) >= n_x) begin
			v3 = VW'(x3 >> 1);
			a3 = a_row_q - AW'(1);
		end else begin
			v3 = VW'(x3);
			a3 = a_row_q;
		end
	end

	// bounds of the exponent search
	assign p5 = (XW'(p_cur_q) << 2) + XW'(p_cur_q);
	assign p3 = (XW'(p_row_q) << 1) + XW'(p_row_q);

	assign st.need_double = v_cur_q < n_q;
	assign st.c_room      = p5 <= XW'(LIMIT);
	assign st.b_room      = p3 <= XW'(LIMIT);

	// search registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q      <= n_clamped;
			v_row_q  <= VW'(2);
			v_cur_q  <= VW'(2);
			a_row_q  <= AW'(1);
			a_cur_q  <= AW'(1);
			p_row_q  <= VW'(2);
			p_cur_q  <= VW'(2);
			b_q      <= '0;
			c_q      <= '0;
			best_q   <= LIMIT;
			best_a_q <= A_TOP;
			best_b_q <= '0;
			best_c_q <= '0;
		end else begin
			if (cmd.dbl) begin
				v_row_q <= v_row_q << 1;
				v_cur_q <= v_cur_q << 1;
				a_row_q <= a_row_q + AW'(1);
				a_cur_q <= a_cur_q + AW'(1);
			end
			if (cmd.visit && v_cur_q < best_q) begin
				best_q   <= v_cur_q;
				best_a_q <= a_cur_q;
				best_b_q <= b_q;
				best_c_q <= c_q;
			end
			// a step along the row takes priority over a step to the next row
			if (cmd.next_c) begin
				v_cur_q <= v5;
				a_cur_q <= a5;
				p_cur_q <= VW'(p5);
				c_q     <= c_q + FIVES_W'(1);
			end else if (cmd.next_b) begin
				v_row_q <= v3;
				a_row_q <= a3;
				v_cur_q <= v3;
				a_cur_q <= a3;
				p_row_q <= VW'(p3);
				p_cur_q <= VW'(p3);
				b_q     <= b_q + THREES_W'(1);
				c_q     <= '0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			chosen_length   <= LEN_W'(best_q);
			twos_exponent   <= TWOS_W'(best_a_q);
			threes_exponent <= best_b_q;
			fives_exponent  <= best_c_q;
		end
	end

endmodule

>>> design/esfs_ctrl.sv
// Controller of the size selector: request handshake, search sequencing, result valid.
module esfs_ctrl import esfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  esfs_stat_t st,
	output esfs_cmd_t  cmd
);

	typedef enum logic [1:0] {
		IDLE,
		INIT,
		SCAN,
		FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE: begin
				cmd.load = in_valid;
			end
			INIT: begin
				cmd.dbl = st.need_double;
			end
			SCAN: begin
				cmd.visit = 1'b1;
				// last cell of the search takes neither step
				if (st.c_room) begin
					cmd.next_c = 1'b1;
				end else if (st.b_room) begin
					cmd.next_b = 1'b1;
				end
			end
			FINISH: begin
				cmd.publish = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= INIT;
					end
				end
				INIT: begin
					if (!st.need_double) begin
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (!st.c_room && !st.b_room) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (cmd.publish) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/even_smooth_fft_size_select.sv
// Top level of the FFT size selector: controller plus datapath behind a request channel and a result channel.
//
// Returns the smallest even length 2^a*3^b*5^c (a >= 1) not below the requested length,
// with its exponents; requests of 2 or less give 2, requests above 2^24 give 2^24. One
// request is worked at a time. The search first doubles 2 up to the request, then visits
// every base 2*3^b*5^c within 2^24, stepping the candidate by x5 or x3 and dropping
// factors of two. The result sits in an output register, so a new request is taken
// while the previous result waits to be read.
module even_smooth_fft_size_select import esfs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	esfs_req_if.sink  request,
	esfs_rsp_if.source result
);

	esfs_cmd_t  cmd;
	esfs_stat_t st;

	esfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.st        (st),
		.cmd       (cmd)
	);

	esfs_dp u_dp (
		.clk             (clk),
		.proposed_length (request.proposed_length),
		.cmd             (cmd),
		.st              (st),
		.chosen_length   (result.chosen_length),
		.twos_exponent   (result.twos_exponent),
		.threes_exponent (result.threes_exponent),
		.fives_exponent  (result.fives_exponent)
	);

endmodule

>>> tb/even_smooth_fft_size_select_tb.sv
// Testbench for even_smooth_fft_size_select: directed and random length requests.
module even_smooth_fft_size_select_tb import esfs_pkg::*; ();

	// One expected answer: chosen length and its exponents
	typedef struct packed {
		logic [LEN_W-1:0]    length;
		logic [TWOS_W-1:0]   twos;
		logic [THREES_W-1:0] threes;
		logic [FIVES_W-1:0]  fives;
	} size_choice_t;

	logic clk;
	logic arst_n;

	esfs_req_if req_ch ();
	esfs_rsp_if rsp_ch ();

	even_smooth_fft_size_select u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.result  (rsp_ch)
	);

	size_choice_t pending_choices[$];
	int           mismatch_count = 0;
	int           idle_pct       = 29;

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n                 = 1'b0;
		req_ch.valid           = 1'b0;
		req_ch.proposed_length = '0;
		rsp_ch.ready           = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("even_smooth_fft_size_select verification failed");
		$finish;
	end

	// Smallest even 2^a*3^b*5^c not below the request, with saturation at the top
	function automatic size_choice_t predict_size(input logic [LEN_W-1:0] request_len);
		longint unsigned ceiling, target, pow3, pow5, cand, best;
		int unsigned     a, b, c, best_a, best_b, best_c;
		size_choice_t    pick;
		ceiling = 64'd1 << LENGTH_BITS;
		target  = request_len;
		if (target > ceiling) target = ceiling;
		if (target < 2) target = 2;
		best   = ceiling;
		best_a = LENGTH_BITS;
		best_b = 0;
		best_c = 0;
		pow3   = 1;
		b      = 0;
		while (2 * pow3 <= ceiling) begin
			pow5 = 1;
			c    = 0;
			while (2 * pow3 * pow5 <= ceiling) begin
				cand = 2 * pow3 * pow5;
				a    = 1;
				// raise the power of two until the candidate covers the request
				while (cand < target) begin
					cand = cand * 2;
					a++;
				end
				if (cand < best) begin
					best   = cand;
					best_a = a;
					best_b = b;
					best_c = c;
				end
				pow5 = pow5 * 5;
				c++;
			end
			pow3 = pow3 * 3;
			b++;
		end
		pick.length = best[LEN_W-1:0];
		pick.twos   = best_a[TWOS_W-1:0];
		pick.threes = best_b[THREES_W-1:0];
		pick.fives  = best_c[FIVES_W-1:0];
		return pick;
	endfunction

	// Result side: random backpressure, driven on the falling edge
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	// Result checker, sampled on the rising edge
	always @(posedge clk) begin
		size_choice_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_choices.size() == 0) begin
				$error("unexpected result: chosen_length %0d", rsp_ch.chosen_length);
				mismatch_count++;
			end else begin
				want = pending_choices.pop_front();
				if (rsp_ch.chosen_length !== want.length) begin
					$error("chosen_length: expected %0d, got %0d",
						want.length, rsp_ch.chosen_length);
					mismatch_count++;
				end
				if (rsp_ch.twos_exponent !== want.twos) begin
					$error("twos_exponent: expected %0d, got %0d",
						want.twos, rsp_ch.twos_exponent);
					mismatch_count++;
				end
				if (rsp_ch.threes_exponent !== want.threes) begin
					$error("threes_exponent: expected %0d, got %0d",
						want.threes, rsp_ch.threes_exponent);
					mismatch_count++;
				end
				if (rsp_ch.fives_exponent !== want.fives) begin
					$error("fives_exponent: expected %0d, got %0d",
						want.fives, rsp_ch.fives_exponent);
					mismatch_count++;
				end
			end
		end
	end

	// Send one request; entered and left just after a falling edge
	task automatic send_request(input logic [LEN_W-1:0] len);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.proposed_length <= len;
		do @(posedge clk); while (!req_ch.ready);
		pending_choices.push_back(predict_size(len));
		@(negedge clk);
	endtask

	// Random even smooth value within 2^24
	function automatic logic [LEN_W-1:0] random_smooth();
		longint unsigned v;
		do begin
			v = 64'd1 << $urandom_range(1, LENGTH_BITS);
			repeat ($urandom_range(0, 14)) v = v * 3;
			repeat ($urandom_range(0, 9)) v = v * 5;
		end while (v > (64'd1 << LENGTH_BITS));
		return v[LEN_W-1:0];
	endfunction

	// Mostly spread over all magnitudes, some near smooth values, a few oversized
	function automatic logic [LEN_W-1:0] random_length();
		int unsigned      pick;
		int unsigned      nbits;
		longint unsigned  v;
		pick = $urandom_range(99);
		if (pick < 35) begin
			v = longint'(random_smooth()) + $urandom_range(0, 2) - 1;
		end else if (pick < 40) begin
			v = $urandom;
			v = v & 64'h1FF_FFFF;
		end else begin
			nbits = $urandom_range(1, LENGTH_BITS);
			v     = $urandom;
			v     = v & ((64'd1 << nbits) - 1);
		end
		return v[LEN_W-1:0];
	endfunction

	// Wait with the request side quiet until every result has come back
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		while (pending_choices.size() != 0) @(negedge clk);
	endtask

	// Requests of 2 or less, and tiny odd values
	task automatic test_small_requests();
		send_request(25'd0);
		send_request(25'd1);
		send_request(25'd2);
		send_request(25'd3);
		send_request(25'd5);
		send_request(25'd7);
		send_request(25'd9);
		send_request(25'd15);
		send_request(25'd31);
	endtask

	// Largest power of three and of five that still fit
	task automatic test_exponent_extremes();
		send_request(25'd9565937);
		send_request(25'd9565938);
		send_request(25'd3906250);
		send_request(25'd3906251);
	endtask

	// Top of range and oversized requests saturating to 2^24
	task automatic test_limit_saturation();
		send_request(25'd8388609);
		send_request(25'd16777215);
		send_request(25'd16777216);
		send_request(25'd16777217);
		send_request(25'h1FF_FFFF);
	endtask

	task automatic test_random_lengths(input int count);
		repeat (count) send_request(random_length());
	endtask

	// Back-to-back requests with no idling on either side
	task automatic test_steady_stream(input int count);
		int saved_pct;
		saved_pct = idle_pct;
		idle_pct  = 0;
		repeat (count) send_request(random_length());
		idle_pct = saved_pct;
	endtask

	// Sender stops until the block has drained, then resumes
	task automatic test_drain_pause(input int count);
		wait_for_results();
		repeat (count) send_request(random_length());
	endtask

	// Test sequence
	initial begin
		@(posedge arst_n);
		@(negedge clk);
		test_small_requests();
		test_exponent_extremes();
		test_limit_saturation();
		test_random_lengths(900);
		test_steady_stream(250);
		test_drain_pause(150);
		req_ch.valid <= 1'b0;
		while (pending_choices.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("even_smooth_fft_size_select verification clean");
		end else begin
			$display("even_smooth_fft_size_select verification failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/esfs_pkg.sv
design/esfs_req_if.sv
design/esfs_rsp_if.sv
design/esfs_dp.sv
design/esfs_ctrl.sv
design/even_smooth_fft_size_select.sv
tb/even_smooth_fft_size_select_tb.sv
